// ----- sv/assert_macros.svh -----
// Concurrent assertion helpers, clocked on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TFP_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`else
`define TFP_ASSERT(lbl, prop, msg)
`define TFP_ASSERT_NEXT(lbl, cond, prop, msg)
`endif
`endif

// ----- sv/tfp_pkg.sv -----
package tfp_pkg;

    localparam int NAME_W = 48;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_NAME  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SECOND_NAME = 1'b1;

    localparam logic [NAME_W-1:0] FIRST_NAME_RESET  = 48'h6C6176652031;
    localparam logic [NAME_W-1:0] SECOND_NAME_RESET = 48'h6C6176652032;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_FIRST  = 2'd1;
    localparam logic [1:0] KIND_SECOND = 2'd2;

    typedef enum logic [2:0] {
        FIELD_NAME   = 3'b001,
        FIELD_FIRST  = 3'b010,
        FIELD_SECOND = 3'b100
    } tfp_field_t;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'b001,
        PH_DIGITS = 3'b010,
        PH_DONE   = 3'b100
    } tfp_phase_t;

    typedef struct packed {
        logic [1:0]         frame_kind;
        logic [7:0]         first_value;
        logic signed [31:0] second_value;
    } tfp_result_t;

endpackage

// ----- sv/tfp_byte_if.sv -----
interface tfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- sv/tfp_result_if.sv -----
interface tfp_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         frame_kind;
    logic [7:0]         first_value;
    logic signed [31:0] second_value;

    modport source (output valid, output frame_kind, output first_value,
                    output second_value, input ready);
    modport sink (input valid, input frame_kind, input first_value,
                  input second_value, output ready);
endinterface

// ----- sv/tfp_cfg_regs.sv -----
module tfp_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [tfp_pkg::CFG_INDEX_W-1:0]  wr_index,
    input  logic [tfp_pkg::NAME_W-1:0]       wr_data,
    output logic [tfp_pkg::NAME_W-1:0]       first_name,
    output logic [tfp_pkg::NAME_W-1:0]       second_name
);

    logic [tfp_pkg::NAME_W-1:0] first_name_reg;
    logic [tfp_pkg::NAME_W-1:0] second_name_reg;
    logic [tfp_pkg::NAME_W-1:0] first_name_next;
    logic [tfp_pkg::NAME_W-1:0] second_name_next;

    always_comb
    begin
        first_name_next  = first_name_reg;
        second_name_next = second_name_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                tfp_pkg::REG_FIRST_NAME:  first_name_next  = wr_data;
                tfp_pkg::REG_SECOND_NAME: second_name_next = wr_data;
                default:                  first_name_next  = first_name_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_name_reg  <= tfp_pkg::FIRST_NAME_RESET;
            second_name_reg <= tfp_pkg::SECOND_NAME_RESET;
        end
        else
        begin
            first_name_reg  <= first_name_next;
            second_name_reg <= second_name_next;
        end
    end

    assign first_name  = first_name_reg;
    assign second_name = second_name_reg;

endmodule

// ----- sv/tfp_name_match.sv -----
module tfp_name_match #(
    parameter int NAME_CHARS = 6
) (
    input  logic [8*NAME_CHARS-1:0]     window,
    input  logic [7:0]                  rx_byte,
    input  logic [tfp_pkg::NAME_W-1:0]  first_name,
    input  logic [tfp_pkg::NAME_W-1:0]  second_name,
    output logic [8*NAME_CHARS-1:0]     window_shift,
    output logic [1:0]                  hits
);

    localparam int NW = 8 * NAME_CHARS;

    logic [NW+7:0] shifted;
    logic [63:0]   first_ext;
    logic [63:0]   second_ext;
    logic [NW-1:0] first_cut;
    logic [NW-1:0] second_cut;

    function automatic logic no_zero_byte(input logic [NW-1:0] n);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < NAME_CHARS; i++)
        begin
            if (n[8*i +: 8] == tfp_pkg::CH_NUL)
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    always_comb
    begin
        shifted      = {window, rx_byte};
        window_shift = shifted[NW-1:0];
        first_ext    = {{(64 - tfp_pkg::NAME_W){1'b0}}, first_name};
        second_ext   = {{(64 - tfp_pkg::NAME_W){1'b0}}, second_name};
        first_cut    = first_ext[NW-1:0];
        second_cut   = second_ext[NW-1:0];
        hits[0]      = no_zero_byte(first_cut) && (window_shift == first_cut);
        hits[1]      = no_zero_byte(second_cut) && (window_shift == second_cut);
    end

endmodule

// ----- sv/tfp_frame_state.sv -----
module tfp_frame_state #(
    parameter int FRAME_BYTES = 40,
    parameter int NAME_CHARS  = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [7:0]                  rx_byte,
    input  logic [tfp_pkg::NAME_W-1:0]  first_name,
    input  logic [tfp_pkg::NAME_W-1:0]  second_name,
    output logic                        emit,
    output tfp_pkg::tfp_result_t        result
);

    localparam int CW = $clog2(FRAME_BYTES + 1);
    localparam int NW = 8 * NAME_CHARS;

    logic [CW-1:0]       count_reg, count_next;
    logic                overflow_reg, overflow_next;
    tfp_pkg::tfp_field_t field_reg, field_next;
    logic                skip_reg, skip_next;
    logic [NW-1:0]       window_reg, window_next;
    logic [1:0]          hits_reg, hits_next;
    tfp_pkg::tfp_phase_t phase_reg, phase_next;
    logic                neg_reg, neg_next;
    logic [31:0]         first_reg, first_next;
    logic [31:0]         second_reg, second_next;

    logic [NW-1:0]       window_shift;
    logic [1:0]          match;

    logic                is_nul, is_hash, is_comma, is_digit, is_space, room;
    logic [31:0]         sel_total, fin_total, dval, times_ten;
    tfp_pkg::tfp_phase_t feed_phase;
    logic                feed_neg;
    logic [31:0]         feed_total;
    logic [1:0]          hits_final, kind;
    logic [31:0]         first_out, second_out;

    tfp_name_match #(
        .NAME_CHARS (NAME_CHARS)
    ) u_name_match (
        .window       (window_reg),
        .rx_byte      (rx_byte),
        .first_name   (first_name),
        .second_name  (second_name),
        .window_shift (window_shift),
        .hits         (match)
    );

    always_comb
    begin
        is_nul    = (rx_byte == tfp_pkg::CH_NUL);
        is_hash   = (rx_byte == tfp_pkg::CH_HASH);
        is_comma  = (rx_byte == tfp_pkg::CH_COMMA);
        is_digit  = (rx_byte >= tfp_pkg::CH_ZERO) && (rx_byte <= tfp_pkg::CH_NINE);
        is_space  = (rx_byte == tfp_pkg::CH_SPACE)
                    || ((rx_byte >= tfp_pkg::CH_TAB) && (rx_byte <= tfp_pkg::CH_CR));
        room      = (count_reg < CW'(FRAME_BYTES));

        sel_total = (field_reg == tfp_pkg::FIELD_FIRST) ? first_reg : second_reg;
        fin_total = neg_reg ? (32'd0 - sel_total) : sel_total;
        dval      = {28'd0, rx_byte[3:0]};
        times_ten = {sel_total[28:0], 3'b000} + {sel_total[30:0], 1'b0};

        feed_phase = phase_reg;
        feed_neg   = neg_reg;
        feed_total = sel_total;
        unique case (phase_reg)
            tfp_pkg::PH_LEAD:
            begin
                if (is_space)
                begin
                    feed_phase = tfp_pkg::PH_LEAD;
                end
                else if (rx_byte == tfp_pkg::CH_PLUS)
                begin
                    feed_phase = tfp_pkg::PH_DIGITS;
                end
                else if (rx_byte == tfp_pkg::CH_MINUS)
                begin
                    feed_neg   = 1'b1;
                    feed_phase = tfp_pkg::PH_DIGITS;
                end
                else if (is_digit)
                begin
                    feed_total = dval;
                    feed_phase = tfp_pkg::PH_DIGITS;
                end
                else
                begin
                    feed_phase = tfp_pkg::PH_DONE;
                end
            end
            tfp_pkg::PH_DIGITS:
            begin
                if (is_digit)
                begin
                    feed_total = times_ten + dval;
                end
                else
                begin
                    feed_phase = tfp_pkg::PH_DONE;
                end
            end
            tfp_pkg::PH_DONE:
            begin
                feed_phase = tfp_pkg::PH_DONE;
            end
            default:
            begin
                feed_phase = phase_reg;
            end
        endcase

        hits_final = (field_reg == tfp_pkg::FIELD_NAME) ? (hits_reg | match) : hits_reg;
        first_out  = (field_reg == tfp_pkg::FIELD_FIRST) ? fin_total : first_reg;
        second_out = (field_reg == tfp_pkg::FIELD_SECOND) ? fin_total : second_reg;
        kind       = hits_final[0] ? tfp_pkg::KIND_FIRST
                   : (hits_final[1] ? tfp_pkg::KIND_SECOND : tfp_pkg::KIND_NONE);

        emit                = is_hash && !overflow_reg && room;
        result.frame_kind   = kind;
        result.first_value  = (kind != tfp_pkg::KIND_NONE) ? first_out[7:0] : 8'd0;
        result.second_value = (kind != tfp_pkg::KIND_NONE) ? $signed(second_out) : 32'sd0;
    end

    always_comb
    begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        field_next    = field_reg;
        skip_next     = skip_reg;
        window_next   = window_reg;
        hits_next     = hits_reg;
        phase_next    = phase_reg;
        neg_next      = neg_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        if (step && !is_nul)
        begin
            if (is_hash)
            begin
                count_next    = '0;
                overflow_next = 1'b0;
                field_next    = tfp_pkg::FIELD_NAME;
                skip_next     = 1'b1;
                window_next   = '0;
                hits_next     = 2'b00;
                phase_next    = tfp_pkg::PH_LEAD;
                neg_next      = 1'b0;
                first_next    = 32'd0;
                second_next   = 32'd0;
            end
            else if (overflow_reg || !room)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CW'(1);
                unique case (field_reg)
                    tfp_pkg::FIELD_NAME:
                    begin
                        if (is_comma)
                        begin
                            if (!skip_reg)
                            begin
                                field_next = tfp_pkg::FIELD_FIRST;
                                skip_next  = 1'b1;
                            end
                        end
                        else
                        begin
                            skip_next   = 1'b0;
                            window_next = window_shift;
                            hits_next   = hits_reg | match;
                        end
                    end
                    tfp_pkg::FIELD_FIRST:
                    begin
                        if (is_comma)
                        begin
                            if (!skip_reg)
                            begin
                                first_next = fin_total;
                                neg_next   = 1'b0;
                                phase_next = tfp_pkg::PH_LEAD;
                                field_next = tfp_pkg::FIELD_SECOND;
                            end
                        end
                        else
                        begin
                            skip_next  = 1'b0;
                            phase_next = feed_phase;
                            neg_next   = feed_neg;
                            first_next = feed_total;
                        end
                    end
                    tfp_pkg::FIELD_SECOND:
                    begin
                        phase_next  = feed_phase;
                        neg_next    = feed_neg;
                        second_next = feed_total;
                    end
                    default:
                    begin
                        field_next = field_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            field_reg    <= tfp_pkg::FIELD_NAME;
            skip_reg     <= 1'b1;
            window_reg   <= '0;
            hits_reg     <= 2'b00;
            phase_reg    <= tfp_pkg::PH_LEAD;
            neg_reg      <= 1'b0;
            first_reg    <= 32'd0;
            second_reg   <= 32'd0;
        end
        else
        begin
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            field_reg    <= field_next;
            skip_reg     <= skip_next;
            window_reg   <= window_next;
            hits_reg     <= hits_next;
            phase_reg    <= phase_next;
            neg_reg      <= neg_next;
            first_reg    <= first_next;
            second_reg   <= second_next;
        end
    end

endmodule

// ----- sv/telemetry_frame_parser_core.sv -----
// Byte-stream parser for '#'-terminated telemetry frames: one link byte is taken per
// word on rx, null bytes are dropped, and each '#' that closes a frame of at most
// FRAME_BYTES bytes yields one word on frames carrying the matched node (first name
// wins), the low byte of the first decimal field and the 32-bit second field. The block
// sustains one byte per clock unless rx stalls; a byte is held in the input register
// while the frame-state update, including the times-ten accumulate, is worked out, and
// a result word is registered as its '#' leaves. rx stalls only while a result waits in
// the output register and the input register holds a '#' yielding another result. Write
// node names on port wr_en/wr_index/wr_data only while idle; the block does not check.
`include "assert_macros.svh"

module telemetry_frame_parser_core #(
    parameter int FRAME_BYTES = 40,
    parameter int NAME_CHARS  = 6
) (
    input  logic                             clk,
    input  logic                             rst_n,
    tfp_byte_if.sink                         rx,
    tfp_result_if.source                     frames,
    input  logic                             wr_en,
    input  logic [tfp_pkg::CFG_INDEX_W-1:0]  wr_index,
    input  logic [tfp_pkg::NAME_W-1:0]       wr_data
);

    logic                       s1_valid_reg, s1_valid_next;
    logic [7:0]                 s1_byte_reg, s1_byte_next;
    logic                       out_valid_reg, out_valid_next;
    tfp_pkg::tfp_result_t       out_result_reg, out_result_next;

    logic [tfp_pkg::NAME_W-1:0] first_name;
    logic [tfp_pkg::NAME_W-1:0] second_name;
    logic                       s1_emit;
    tfp_pkg::tfp_result_t       s1_result;
    logic                       out_free;
    logic                       s1_fire;
    logic                       rx_take;

    tfp_cfg_regs u_cfg_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .first_name  (first_name),
        .second_name (second_name)
    );

    tfp_frame_state #(
        .FRAME_BYTES (FRAME_BYTES),
        .NAME_CHARS  (NAME_CHARS)
    ) u_frame_state (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (s1_fire),
        .rx_byte     (s1_byte_reg),
        .first_name  (first_name),
        .second_name (second_name),
        .emit        (s1_emit),
        .result      (s1_result)
    );

    always_comb
    begin
        out_free  = !out_valid_reg || frames.ready;
        s1_fire   = s1_valid_reg && (!s1_emit || out_free);
        rx.ready  = !s1_valid_reg || s1_fire;
        rx_take   = rx.valid && rx.ready;

        s1_valid_next = s1_valid_reg;
        s1_byte_next  = s1_byte_reg;
        if (rx_take)
        begin
            s1_valid_next = 1'b1;
            s1_byte_next  = rx.rx_byte;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next  = out_valid_reg && !frames.ready;
        out_result_next = out_result_reg;
        if (s1_fire && s1_emit)
        begin
            out_valid_next  = 1'b1;
            out_result_next = s1_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_byte_reg    <= s1_byte_next;
        out_result_reg <= out_result_next;
    end

    assign frames.valid        = out_valid_reg;
    assign frames.frame_kind   = out_result_reg.frame_kind;
    assign frames.first_value  = out_result_reg.first_value;
    assign frames.second_value = out_result_reg.second_value;

    `TFP_ASSERT(a_kind_legal,
        !frames.valid || (frames.frame_kind == tfp_pkg::KIND_NONE)
        || (frames.frame_kind == tfp_pkg::KIND_FIRST)
        || (frames.frame_kind == tfp_pkg::KIND_SECOND),
        "illegal frame kind")
    `TFP_ASSERT(a_unknown_zero,
        !(frames.valid && (frames.frame_kind == tfp_pkg::KIND_NONE))
        || ((frames.first_value == 8'd0) && (frames.second_value == 32'sd0)),
        "unrecognised frame carries values")
    `TFP_ASSERT(a_stall_cause,
        rx.ready || (s1_valid_reg && out_valid_reg && !frames.ready),
        "rx stalled without a full output")
    `TFP_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !s1_fire,
        s1_valid_reg && $stable(s1_byte_reg), "held byte lost")

endmodule

// ----- tb/telemetry_frame_parser_core_test.sv -----
`timescale 1ns / 1ps

module telemetry_frame_parser_core_test;

    localparam int FRAME_LIMIT   = 40;
    localparam int SETTLE_CYCLES = 8;
    localparam int NOTE_LIMIT    = 40;

    logic                            clk;
    logic                            rst_n;
    logic                            wr_en;
    logic [tfp_pkg::CFG_INDEX_W-1:0] wr_index;
    logic [tfp_pkg::NAME_W-1:0]      wr_data;

    tfp_byte_if   rx_if();
    tfp_result_if frames_if();

    telemetry_frame_parser_core #(
        .FRAME_BYTES(FRAME_LIMIT),
        .NAME_CHARS (6)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_if),
        .frames  (frames_if),
        .wr_en   (wr_en),
        .wr_index(wr_index),
        .wr_data (wr_data)
    );

    logic [tfp_pkg::NAME_W-1:0] name_first;
    logic [tfp_pkg::NAME_W-1:0] name_second;

    int                         frame_len;
    bit                         overlong;
    tfp_pkg::tfp_field_t        field_pos;
    bit                         comma_skip;
    logic [tfp_pkg::NAME_W-1:0] tail_chars;
    logic [1:0]                 node_seen;
    tfp_pkg::tfp_phase_t        num_phase;
    bit                         num_minus;
    logic [31:0]                acc_first;
    logic [31:0]                acc_second;

    tfp_pkg::tfp_result_t expected_frames[$];
    logic [7:0]           link_bytes[$];

    int mismatch_count;
    int bytes_sent;
    int stall_left;
    bit idle_enable;
    bit stall_enable;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void restart_frame();
        frame_len  = 0;
        overlong   = 1'b0;
        field_pos  = tfp_pkg::FIELD_NAME;
        comma_skip = 1'b1;
        tail_chars = '0;
        node_seen  = '0;
        num_phase  = tfp_pkg::PH_LEAD;
        num_minus  = 1'b0;
        acc_first  = '0;
        acc_second = '0;
    endfunction

    function automatic bit node_present(input logic [tfp_pkg::NAME_W-1:0] node);
        for (int i = 0; i < 6; i++)
            if (node[8*i +: 8] == tfp_pkg::CH_NUL)
                return 1'b0;
        return tail_chars == node;
    endfunction

    function automatic void shift_in_char(input logic [7:0] b);
        tail_chars = {tail_chars[tfp_pkg::NAME_W-9:0], b};
        if (node_present(name_first))
            node_seen[0] = 1'b1;
        if (node_present(name_second))
            node_seen[1] = 1'b1;
    endfunction

    function automatic bit is_blank(input logic [7:0] b);
        return b == tfp_pkg::CH_SPACE || (b >= tfp_pkg::CH_TAB && b <= tfp_pkg::CH_CR);
    endfunction

    function automatic logic [31:0] accumulate(input logic [7:0] b, input logic [31:0] acc);
        logic        digit;
        logic [31:0] unit;
        digit = b >= tfp_pkg::CH_ZERO && b <= tfp_pkg::CH_NINE;
        unit  = {24'd0, 8'(b - tfp_pkg::CH_ZERO)};
        case (num_phase)
            tfp_pkg::PH_LEAD:
            begin
                if (b == tfp_pkg::CH_PLUS)
                    num_phase = tfp_pkg::PH_DIGITS;
                else if (b == tfp_pkg::CH_MINUS)
                begin
                    num_minus = 1'b1;
                    num_phase = tfp_pkg::PH_DIGITS;
                end
                else if (digit)
                begin
                    acc       = unit;
                    num_phase = tfp_pkg::PH_DIGITS;
                end
                else if (!is_blank(b))
                    num_phase = tfp_pkg::PH_DONE;
            end
            tfp_pkg::PH_DIGITS:
            begin
                if (digit)
                    acc = acc * 32'd10 + unit;
                else
                    num_phase = tfp_pkg::PH_DONE;
            end
            default:
            begin
            end
        endcase
        return acc;
    endfunction

    function automatic logic [31:0] close_value(input logic [31:0] acc);
        logic [31:0] v;
        v         = num_minus ? 32'd0 - acc : acc;
        num_minus = 1'b0;
        num_phase = tfp_pkg::PH_LEAD;
        return v;
    endfunction

    function automatic void take_link_byte(input logic [7:0] b);
        tfp_pkg::tfp_result_t r;
        if (b == tfp_pkg::CH_NUL)
            return;
        if (b == tfp_pkg::CH_HASH)
        begin
            if (!overlong && frame_len + 1 <= FRAME_LIMIT)
            begin
                case (field_pos)
                    tfp_pkg::FIELD_NAME:   shift_in_char(b);
                    tfp_pkg::FIELD_FIRST:  acc_first = close_value(acc_first);
                    tfp_pkg::FIELD_SECOND: acc_second = close_value(acc_second);
                    default:
                    begin
                    end
                endcase
                r.frame_kind   = node_seen[0] ? tfp_pkg::KIND_FIRST :
                                 (node_seen[1] ? tfp_pkg::KIND_SECOND : tfp_pkg::KIND_NONE);
                r.first_value  = (r.frame_kind != tfp_pkg::KIND_NONE) ? acc_first[7:0] : 8'd0;
                r.second_value = (r.frame_kind != tfp_pkg::KIND_NONE) ? acc_second : 32'd0;
                expected_frames.push_back(r);
            end
            restart_frame();
            return;
        end
        if (overlong || frame_len >= FRAME_LIMIT)
        begin
            overlong = 1'b1;
            return;
        end
        frame_len++;
        case (field_pos)
            tfp_pkg::FIELD_NAME:
            begin
                if (b == tfp_pkg::CH_COMMA)
                begin
                    if (!comma_skip)
                    begin
                        field_pos  = tfp_pkg::FIELD_FIRST;
                        comma_skip = 1'b1;
                    end
                end
                else
                begin
                    comma_skip = 1'b0;
                    shift_in_char(b);
                end
            end
            tfp_pkg::FIELD_FIRST:
            begin
                if (b == tfp_pkg::CH_COMMA)
                begin
                    if (!comma_skip)
                    begin
                        acc_first = close_value(acc_first);
                        field_pos = tfp_pkg::FIELD_SECOND;
                    end
                end
                else
                begin
                    comma_skip = 1'b0;
                    acc_first  = accumulate(b, acc_first);
                end
            end
            tfp_pkg::FIELD_SECOND: acc_second = accumulate(b, acc_second);
            default:
            begin
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < NOTE_LIMIT)
            $display("ERROR at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_frame();
        tfp_pkg::tfp_result_t want;
        if (expected_frames.size() == 0)
        begin
            report_mismatch($sformatf("frame word with none expected, kind %0d",
                                      frames_if.frame_kind));
            return;
        end
        want = expected_frames.pop_front();
        if (frames_if.frame_kind !== want.frame_kind)
            report_mismatch($sformatf("frame_kind %0d, expected %0d",
                                      frames_if.frame_kind, want.frame_kind));
        if (frames_if.first_value !== want.first_value)
            report_mismatch($sformatf("first_value %0d, expected %0d",
                                      frames_if.first_value, want.first_value));
        if (frames_if.second_value !== want.second_value)
            report_mismatch($sformatf("second_value %0d, expected %0d",
                                      frames_if.second_value, want.second_value));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            frames_if.ready <= 1'b0;
        else
        begin
            if (frames_if.valid && frames_if.ready)
                check_frame();
            if (stall_left > 0)
            begin
                stall_left--;
                frames_if.ready <= 1'b0;
            end
            else if (stall_enable && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 18);
                frames_if.ready <= 1'b0;
            end
            else
                frames_if.ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (idle_enable && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 19);
        if (gap > 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_if.ready);
        take_link_byte(b);
        if (b != tfp_pkg::CH_NUL)
            bytes_sent++;
    endtask

    task automatic send_link_bytes();
        logic [7:0] b;
        while (link_bytes.size() > 0)
        begin
            b = link_bytes.pop_front();
            if ($urandom_range(0, 39) == 0)
                send_byte(tfp_pkg::CH_NUL);
            send_byte(b);
        end
    endtask

    task automatic wait_idle();
        rx_if.valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_node_name(input logic [tfp_pkg::CFG_INDEX_W-1:0] index,
                                   input logic [tfp_pkg::NAME_W-1:0] name);
        wr_en    <= 1'b1;
        wr_index <= index;
        wr_data  <= name;
        @(posedge clk);
        wr_en <= 1'b0;
        if (index == tfp_pkg::REG_FIRST_NAME)
            name_first = name;
        else
            name_second = name;
        @(posedge clk);
    endtask

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            link_bytes.push_back(s[i]);
    endfunction

    function automatic void push_name(input logic [tfp_pkg::NAME_W-1:0] name);
        for (int i = 5; i >= 0; i--)
            link_bytes.push_back(name[8*i +: 8]);
    endfunction

    function automatic logic [7:0] random_field_char();
        logic [7:0] c;
        c = 8'($urandom_range(8'h20, 8'h7E));
        while (c == tfp_pkg::CH_COMMA || c == tfp_pkg::CH_HASH)
            c = 8'($urandom_range(8'h20, 8'h7E));
        return c;
    endfunction

    function automatic logic [tfp_pkg::NAME_W-1:0] random_node_name();
        logic [tfp_pkg::NAME_W-1:0] n;
        int                         pos;
        n   = '0;
        pos = $urandom_range(0, 5);
        for (int i = 0; i < 6; i++)
            n = {n[tfp_pkg::NAME_W-9:0], random_field_char()};
        case ($urandom_range(0, 11))
            0: n = '0;
            1: n = '1;
            2: n[8*pos +: 8] = tfp_pkg::CH_NUL;
            3: n[8*pos +: 8] = tfp_pkg::CH_COMMA;
            4: n = tfp_pkg::FIRST_NAME_RESET;
            5: n = tfp_pkg::SECOND_NAME_RESET;
            default:
            begin
            end
        endcase
        return n;
    endfunction

    function automatic void push_value();
        int blanks;
        int digits;
        blanks = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        digits = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 4);
        repeat (blanks)
            link_bytes.push_back(($urandom_range(0, 6) == 0) ? tfp_pkg::CH_SPACE
                                                             : 8'($urandom_range(9, 13)));
        case ($urandom_range(0, 5))
            0: link_bytes.push_back(tfp_pkg::CH_PLUS);
            1: link_bytes.push_back(tfp_pkg::CH_MINUS);
            default:
            begin
            end
        endcase
        repeat (digits)
            link_bytes.push_back(8'(tfp_pkg::CH_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 5) == 0)
            link_bytes.push_back(random_field_char());
    endfunction

    function automatic void push_frame();
        int choice;
        choice = $urandom_range(0, 9);
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 2)) link_bytes.push_back(tfp_pkg::CH_COMMA);
        repeat ($urandom_range(0, 3)) link_bytes.push_back(random_field_char());
        if (choice <= 3)
            push_name(name_first);
        else if (choice <= 6)
            push_name(name_second);
        else if (choice == 7)
        begin
            push_name(name_second);
            push_name(name_first);
        end
        repeat ($urandom_range(0, 2)) link_bytes.push_back(random_field_char());
        if ($urandom_range(0, 14) == 0)
            repeat ($urandom_range(30, 45)) link_bytes.push_back(random_field_char());
        if ($urandom_range(0, 9) != 0)
        begin
            repeat ($urandom_range(1, 2)) link_bytes.push_back(tfp_pkg::CH_COMMA);
            push_value();
            if ($urandom_range(0, 6) != 0)
            begin
                link_bytes.push_back(tfp_pkg::CH_COMMA);
                push_value();
            end
        end
        link_bytes.push_back(tfp_pkg::CH_HASH);
    endfunction

    task automatic test_node_match();
        push_text("lave 1,12,-34#");
        push_text(",,lave 2 x,,+7,  99z#");
        push_text("lave 2lave 1,1,2#");
        push_text("nobody,5,6#");
        push_text("lave 1#");
        send_link_bytes();
    endtask

    task automatic test_value_forms();
        push_text("lave 1, \t-,4294967297#");
        push_text("lave 2,\r+300,-2147483648#");
        push_text("lave 1,255#");
        send_link_bytes();
    endtask

    task automatic test_frame_limit();
        for (int extra = 0; extra < 2; extra++)
        begin
            push_text("lave 1,");
            repeat (FRAME_LIMIT - 10 + extra) link_bytes.push_back(tfp_pkg::CH_NINE);
            link_bytes.push_back(tfp_pkg::CH_NUL);
            push_text(",5#");
        end
        push_text("lave 2,3,4#");
        send_link_bytes();
    endtask

    task automatic test_name_registers();
        wait_idle();
        write_node_name(tfp_pkg::REG_FIRST_NAME, '0);
        write_node_name(tfp_pkg::REG_SECOND_NAME, '1);
        push_name('1);
        push_text(",3,4#lave 1,1,1#");
        send_link_bytes();
        wait_idle();
        write_node_name(tfp_pkg::REG_FIRST_NAME, 48'h61622C636465);
        write_node_name(tfp_pkg::REG_SECOND_NAME, 48'h6E6F64650031);
        push_text("ab,cde,1,2#node1,1,2#");
        send_link_bytes();
    endtask

    task automatic test_random_traffic(input int byte_budget);
        int stop_at;
        wait_idle();
        write_node_name(tfp_pkg::REG_FIRST_NAME, random_node_name());
        write_node_name(tfp_pkg::REG_SECOND_NAME, random_node_name());
        stop_at = bytes_sent + byte_budget;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(0, 6) == 0)
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
            else
            begin
                push_frame();
                send_link_bytes();
            end
        end
        send_byte(tfp_pkg::CH_HASH);
    endtask

    task automatic test_steady_stream(input int byte_budget);
        idle_enable  = 1'b0;
        stall_enable = 1'b0;
        test_random_traffic(byte_budget);
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        rx_if.valid     <= 1'b0;
        rx_if.rx_byte   <= tfp_pkg::CH_NUL;
        wr_en           <= 1'b0;
        wr_index        <= tfp_pkg::REG_FIRST_NAME;
        wr_data         <= '0;
        mismatch_count  = 0;
        bytes_sent      = 0;
        stall_left      = 0;
        idle_enable     = 1'b1;
        stall_enable    = 1'b1;
        name_first      = tfp_pkg::FIRST_NAME_RESET;
        name_second     = tfp_pkg::SECOND_NAME_RESET;
        restart_frame();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_node_match();
        test_value_forms();
        test_frame_limit();
        test_name_registers();
        repeat (4) test_random_traffic(170);
        test_steady_stream(150);

        wait_idle();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
